// ----- design/i2a_pkg.sv -----
// Shared constants, item kind codes and character helpers for the integer to ASCII formatter.
package i2a_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int OPCODE_W = 2;
  localparam int CHAR_W = 7;
  localparam int KIND_W = 2;

  localparam logic [OPCODE_W-1:0] OP_DEC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_HEX = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_PFX = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DEC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PFX = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X = 7'h78;

  typedef struct packed {
    logic push;
    logic [KIND_W-1:0] kind;
  } push_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    unique case (nib)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'hA: c = 7'h41;
      4'hB: c = 7'h42;
      4'hC: c = 7'h43;
      4'hD: c = 7'h44;
      4'hE: c = 7'h45;
      4'hF: c = 7'h46;
    endcase
    return c;
  endfunction

endpackage

// ----- design/i2a_front.sv -----
// Front end: accepts items, classifies the opcode and drops unused codes.
module i2a_front (
  input  logic start,
  input  logic [i2a_pkg::OPCODE_W-1:0] opcode,
  input  logic full,
  output logic busy,
  output i2a_pkg::push_t push
);

  assign busy = full;

  always_comb begin
    push.push = start && !full;
    push.kind = i2a_pkg::KIND_DEC;
    unique case (opcode)
      i2a_pkg::OP_DEC: push.kind = i2a_pkg::KIND_DEC;
      i2a_pkg::OP_HEX: push.kind = i2a_pkg::KIND_HEX;
      i2a_pkg::OP_PFX: push.kind = i2a_pkg::KIND_PFX;
      default: push.push = 1'b0;
    endcase
  end

endmodule

// ----- design/i2a_queue.sv -----
// Short register queue between the front end and the conversion back end.
module i2a_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = i2a_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic pop,
  output logic [WIDTH-1:0] rd_data,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign empty = (count == '0);
  assign full = (count == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/i2a_back.sv -----
// Back end: double-dabble decimal conversion, hex digit walk and character output.
module i2a_back #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  logic [VALUE_BITS-1:0] job_value,
  input  logic [i2a_pkg::KIND_W-1:0] job_kind,
  output logic pop,
  output logic valid,
  output logic [i2a_pkg::CHAR_W-1:0] text_char,
  output logic last
);

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DIG_W = DEC_DIGITS * 4;
  localparam int HEX_W = HEX_DIGITS * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DAB = 3'd1;
  localparam logic [2:0] S_DEC = 3'd2;
  localparam logic [2:0] S_PFX0 = 3'd3;
  localparam logic [2:0] S_PFXX = 3'd4;
  localparam logic [2:0] S_HEX = 3'd5;

  logic [2:0] state;
  logic [CNT_W-1:0] cnt;
  logic started;
  logic [DIG_W-1:0] digits;
  logic [VALUE_BITS-1:0] bin;
  logic [DIG_W-1:0] adj;
  logic [3:0] top_nib;

  assign pop = (state == S_IDLE) && !empty;
  assign top_nib = digits[DIG_W-1 -: 4];

  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      adj[d*4 +: 4] = (digits[d*4 +: 4] >= 4'd5) ? digits[d*4 +: 4] + 4'd3
                                                  : digits[d*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          bin <= job_value;
          if (job_kind == i2a_pkg::KIND_DEC) begin
            digits <= '0;
          end else begin
            digits <= DIG_W'(job_value) << (DIG_W - HEX_W);
          end
        end
      end
      S_DAB: begin
        {digits, bin} <= {adj, bin} << 1;
      end
      S_DEC, S_HEX: begin
        digits <= digits << 4;
      end
      default: begin
        digits <= digits;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      started <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          started <= 1'b0;
          if (!empty) begin
            unique case (job_kind)
              i2a_pkg::KIND_DEC: begin
                state <= S_DAB;
                cnt <= CNT_W'(VALUE_BITS);
              end
              i2a_pkg::KIND_HEX: begin
                state <= S_HEX;
                cnt <= CNT_W'(HEX_DIGITS);
              end
              i2a_pkg::KIND_PFX: begin
                state <= S_PFX0;
                cnt <= CNT_W'(HEX_DIGITS);
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DAB: begin
          if (cnt == CNT_W'(1)) begin
            state <= S_DEC;
            cnt <= CNT_W'(DEC_DIGITS);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DEC: begin
          if (started || top_nib != 4'd0 || cnt == CNT_W'(1)) begin
            valid <= 1'b1;
            started <= 1'b1;
          end
          if (cnt == CNT_W'(1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt - 1'b1;
        end
        S_PFX0: begin
          valid <= 1'b1;
          state <= S_PFXX;
        end
        S_PFXX: begin
          valid <= 1'b1;
          state <= S_HEX;
        end
        S_HEX: begin
          valid <= 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_IDLE;
          end
          cnt <= cnt - 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_PFX0: begin
        text_char <= i2a_pkg::CHAR_ZERO;
        last <= 1'b0;
      end
      S_PFXX: begin
        text_char <= i2a_pkg::CHAR_X;
        last <= 1'b0;
      end
      default: begin
        text_char <= i2a_pkg::hex_char(top_nib);
        last <= (cnt == CNT_W'(1));
      end
    endcase
  end

endmodule

// ----- design/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter: front end, item queue and conversion back end.
// Each item writes one number as ASCII text, one character per cycle on text_char with valid
// high, most significant first, last marking the final character. Opcode 0 gives decimal with
// no leading zeros, opcode 1 gives full-width uppercase hex, opcode 2 puts "0x" before the hex;
// opcode 3 is taken and dropped. The receiver cannot stall: each character is shown for
// exactly one cycle. Items are taken while the two-entry queue has room; busy is high when it
// is full. The back end handles one item at a time: a decimal item runs shift-and-add-3 over
// all VALUE_BITS bits and then walks each decimal digit position (leading zeros are walked
// over without output); a hex item walks all VALUE_BITS/4 digits (rounded up), after the
// two prefix characters with opcode 2.
module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [i2a_pkg::OPCODE_W-1:0] opcode,
  output logic valid,
  output logic [i2a_pkg::CHAR_W-1:0] text_char,
  output logic last
);

  localparam int JOB_W = VALUE_BITS + i2a_pkg::KIND_W;

  i2a_pkg::push_t push;
  logic full;
  logic empty;
  logic pop;
  logic [JOB_W-1:0] job;

  i2a_front u_front (
    .start(start),
    .opcode(opcode),
    .full(full),
    .busy(busy),
    .push(push)
  );

  i2a_queue #(
    .WIDTH(JOB_W),
    .DEPTH(i2a_pkg::QUEUE_DEPTH_DEFAULT)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push.push),
    .wr_data({push.kind, value}),
    .pop(pop),
    .rd_data(job),
    .empty(empty),
    .full(full)
  );

  i2a_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .job_value(job[VALUE_BITS-1:0]),
    .job_kind(job[JOB_W-1 -: i2a_pkg::KIND_W]),
    .pop(pop),
    .valid(valid),
    .text_char(text_char),
    .last(last)
  );

endmodule

// ----- tb/sv/integer_to_ascii_formatter_test.sv -----
// Testbench for the integer to ASCII formatter: directed table, random items, character check.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;

  localparam logic [i2a_pkg::OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam logic [i2a_pkg::CHAR_W-1:0] CHAR_A = 7'h41;
  localparam int RANDOM_ITEMS = 437;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [31:0] value;
  logic [i2a_pkg::OPCODE_W-1:0] opcode;
  logic valid;
  logic [i2a_pkg::CHAR_W-1:0] text_char;
  logic last;

  logic [i2a_pkg::CHAR_W-1:0] pending_chars[$];
  logic pending_last[$];
  int mismatch_count = 0;
  int stall_cycles = 0;

  logic [31:0] row_value[$];
  logic [i2a_pkg::OPCODE_W-1:0] row_op[$];
  bit row_typed[$];
  string row_text[$];

  integer_to_ascii_formatter uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .opcode(opcode),
    .valid(valid),
    .text_char(text_char),
    .last(last)
  );

  always #5 clk = ~clk;

  function automatic void predict_text(input logic [31:0] num,
                                       input logic [i2a_pkg::OPCODE_W-1:0] op);
    logic [i2a_pkg::CHAR_W-1:0] chars[$];
    logic [i2a_pkg::CHAR_W-1:0] ch;
    logic [31:0] rest;
    logic [3:0] nib;
    int k;
    rest = num;
    case (op)
      i2a_pkg::OP_DEC: begin
        do begin
          ch = i2a_pkg::CHAR_W'(i2a_pkg::CHAR_ZERO + rest % 10);
          chars.push_front(ch);
          rest = rest / 10;
        end while (rest != 0);
      end
      i2a_pkg::OP_HEX, i2a_pkg::OP_PFX: begin
        if (op == i2a_pkg::OP_PFX) begin
          chars.push_back(i2a_pkg::CHAR_ZERO);
          chars.push_back(i2a_pkg::CHAR_X);
        end
        for (k = 7; k >= 0; k--) begin
          nib = num[4*k +: 4];
          if (nib < 10) ch = i2a_pkg::CHAR_ZERO + nib;
          else ch = i2a_pkg::CHAR_W'(CHAR_A + (nib - 10));
          chars.push_back(ch);
        end
      end
      default: ;
    endcase
    for (k = 0; k < chars.size(); k++) begin
      pending_chars.push_back(chars[k]);
      pending_last.push_back(k == chars.size() - 1);
    end
  endfunction

  task automatic add_row(input logic [31:0] v, input logic [i2a_pkg::OPCODE_W-1:0] op,
                         input bit typed, input string text);
    row_value.push_back(v);
    row_op.push_back(op);
    row_typed.push_back(typed);
    row_text.push_back(text);
  endtask

  task automatic drive_item(input logic [31:0] v, input logic [i2a_pkg::OPCODE_W-1:0] op,
                            input int gap, input bit typed, input string text);
    logic [i2a_pkg::CHAR_W-1:0] ch;
    int i;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    opcode <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (typed) begin
      for (i = 0; i < text.len(); i++) begin
        ch = i2a_pkg::CHAR_W'(text[i]);
        pending_chars.push_back(ch);
        pending_last.push_back(i == text.len() - 1);
      end
    end else begin
      predict_text(v, op);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (valid) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual text_char=%h last=%b",
                   $time, text_char, last);
          mismatch_count++;
        end else begin
          if (text_char !== pending_chars[0] || last !== pending_last[0]) begin
            $display("%0t: mismatch: expected text_char=%h last=%b, actual text_char=%h last=%b",
                     $time, pending_chars[0], pending_last[0], text_char, last);
            mismatch_count++;
          end
          void'(pending_chars.pop_front());
          void'(pending_last.pop_front());
        end
      end
      if (valid || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] v;
    logic [i2a_pkg::OPCODE_W-1:0] op;
    int p;
    int n;
    int gap;
    bit idle_on;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    opcode = i2a_pkg::OP_DEC;

    add_row(32'd0, i2a_pkg::OP_DEC, 1, "0");
    add_row(32'd0, i2a_pkg::OP_HEX, 1, "00000000");
    add_row(32'd0, i2a_pkg::OP_PFX, 1, "0x00000000");
    add_row(32'hFFFFFFFF, i2a_pkg::OP_DEC, 1, "4294967295");
    add_row(32'hFFFFFFFF, i2a_pkg::OP_HEX, 1, "FFFFFFFF");
    add_row(32'hFFFFFFFF, i2a_pkg::OP_PFX, 1, "0xFFFFFFFF");
    add_row(32'd9, i2a_pkg::OP_DEC, 1, "9");
    add_row(32'd10, i2a_pkg::OP_DEC, 1, "10");
    add_row(32'd1, i2a_pkg::OP_DEC, 0, "");
    add_row(32'd99, i2a_pkg::OP_DEC, 0, "");
    add_row(32'd100, i2a_pkg::OP_DEC, 0, "");
    add_row(32'd999999999, i2a_pkg::OP_DEC, 0, "");
    add_row(32'd1000000000, i2a_pkg::OP_DEC, 0, "");
    add_row(32'h80000000, i2a_pkg::OP_DEC, 0, "");
    add_row(32'hA5A5A5A5, i2a_pkg::OP_DEC, 0, "");
    add_row(32'h12345678, i2a_pkg::OP_HEX, 1, "12345678");
    add_row(32'h5A5A5A5A, i2a_pkg::OP_HEX, 0, "");
    add_row(32'hDEADBEEF, i2a_pkg::OP_PFX, 0, "");
    add_row(32'h00000001, i2a_pkg::OP_PFX, 0, "");
    add_row(32'd0, OP_NONE, 1, "");
    add_row(32'hFFFFFFFF, OP_NONE, 1, "");
    add_row(32'h12345678, OP_NONE, 0, "");
    add_row(32'd7, i2a_pkg::OP_DEC, 0, "");

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < row_value.size(); n++) begin
      drive_item(row_value[n], row_op[n], $urandom_range(0, 10), row_typed[n], row_text[n]);
    end

    idle_on = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 99);
        2: begin
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          v = p + $urandom_range(0, 2) - 1;
        end
        default: v = $urandom | 32'h80000000;
      endcase
      op = ($urandom_range(0, 9) == 0) ? OP_NONE
                                        : i2a_pkg::OPCODE_W'($urandom_range(0, 2));
      gap = idle_on ? $urandom_range(0, 10) : 0;
      drive_item(v, op, gap, 0, "");
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
